// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL of the category 019 record validator.
// Standalone header; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AST_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define AST_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define AST_ASSERT(label, clk, rst, prop, msg)
`define AST_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// ===== rtl/ast19_pkg.sv =====
// Types, codes and the item table of the category 019 record validator.
// No dependencies; imported by every module of the block.
`default_nettype none
package ast19_pkg;

   localparam int MAX_MESSAGE_BYTES_DEF = 65535;
   localparam int ITEM_COUNT = 14;
   localparam int POS_W = 4;
   localparam logic [7:0] CATEGORY_CODE = 8'd19;
   localparam logic [7:0] SPARE_MASK = 8'h18;

   localparam logic [7:0] K_SPARE = 8'h00;
   localparam logic [7:0] K_REPEAT = 8'h80;
   localparam logic [7:0] K_EXTEND = 8'h81;
   localparam logic [7:0] K_EXPLICIT = 8'h82;

   typedef logic [POS_W-1:0] pos_type;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_FSPEC,
      PH_FSPEC_CONT,
      PH_ITEM_START,
      PH_ITEM_SKIP,
      PH_ITEM_EXT,
      PH_STOPPED
   } phase_type;

   typedef enum logic [3:0] {
      ST_OK,
      ST_OVERSIZE,
      ST_SHORT_HEADER,
      ST_CATEGORY,
      ST_LENGTH_OVER,
      ST_FSPEC_OVERRUN,
      ST_SPARE,
      ST_THIRD_FSPEC,
      ST_RECORD_OVERRUN
   } status_type;

   typedef struct packed {
      logic fire;
      logic last;
      logic hdr_done;
      logic cat_ok;
      logic step_en;
      logic fx_at_end;
   } parse_ctrl_type;

   typedef struct packed {
      logic        phase_fspec;
      status_type  error;
      logic [15:0] records;
   } parse_view_type;

   function automatic logic [7:0] item_kind(input pos_type pos);
      logic [7:0] kind;
      case (pos)
         4'd0:    kind = 8'd2;
         4'd1:    kind = 8'd1;
         4'd2:    kind = 8'd3;
         4'd3:    kind = 8'd1;
         4'd4:    kind = 8'd1;
         4'd5:    kind = K_REPEAT;
         4'd6:    kind = K_EXTEND;
         4'd7:    kind = 8'd8;
         4'd8:    kind = 8'd2;
         4'd9:    kind = 8'd1;
         4'd12:   kind = K_EXPLICIT;
         4'd13:   kind = K_EXPLICIT;
         default: kind = K_SPARE;
      endcase
      return kind;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/ast19_item_search.sv =====
// Finds the first item marked present in the FSPEC at or after a start position.
// Depends on ast19_pkg for the item table.
`default_nettype none
module ast19_item_search import ast19_pkg::*; (
   input  wire logic [7:0] fspec_first,
   input  wire logic [7:0] fspec_second,
   input  wire logic [1:0] fspec_octets,
   input  wire pos_type    start,
   output pos_type         found,
   output logic            none
);

   logic [ITEM_COUNT-1:0] present;

   always_comb begin
      for (int p = 0; p < 7; p++) begin
         present[p] = fspec_first[7-p];
      end
      for (int p = 7; p < ITEM_COUNT; p++) begin
         present[p] = (fspec_octets >= 2'd2) && (item_kind(POS_W'(p)) != K_SPARE) &&
                      fspec_second[14-p];
      end
   end

   always_comb begin
      found = POS_W'(ITEM_COUNT);
      for (int p = ITEM_COUNT - 1; p >= 0; p--) begin
         if (present[p] && (POS_W'(p) >= start)) begin
            found = POS_W'(p);
         end
      end
      none = (found == POS_W'(ITEM_COUNT));
   end

endmodule
`default_nettype wire

// ===== rtl/ast19_record_parser.sv =====
// Record walker: FSPEC octets, item skipping and the record count.
// Depends on ast19_pkg and ast19_item_search.
`default_nettype none
module ast19_record_parser import ast19_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire parse_ctrl_type ctrl,
   input  wire logic [7:0]     data_byte,
   output parse_view_type      view
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  fspec_first_ff, fspec_first_in;
   logic [7:0]  fspec_second_ff, fspec_second_in;
   logic [1:0]  fspec_octets_ff, fspec_octets_in;
   pos_type     pos_ff, pos_in;
   logic [8:0]  skip_ff, skip_in;
   status_type  error_ff, error_in;
   logic [15:0] records_ff, records_in;

   logic [7:0]  fs_first, fs_second;
   logic [1:0]  fs_octets;
   pos_type     srch_start, found;
   logic        none;
   phase_type   adv_phase;
   logic [15:0] adv_records;
   logic [7:0]  kind;
   logic [8:0]  skip_dec;
   logic        step;

   always_comb begin
      fs_first = fspec_first_ff;
      fs_second = fspec_second_ff;
      fs_octets = fspec_octets_ff;
      srch_start = POS_W'(pos_ff + POS_W'(1));
      if (phase_ff == PH_FSPEC) begin
         fs_first = data_byte;
         fs_second = 8'h00;
         fs_octets = 2'd1;
         srch_start = '0;
      end else if (phase_ff == PH_FSPEC_CONT) begin
         if (fspec_octets_ff == 2'd1) begin
            fs_second = data_byte;
         end
         if (fspec_octets_ff < 2'd3) begin
            fs_octets = fspec_octets_ff + 2'd1;
         end
         srch_start = '0;
      end
   end

   ast19_item_search u_search (
      .fspec_first  (fs_first),
      .fspec_second (fs_second),
      .fspec_octets (fs_octets),
      .start        (srch_start),
      .found        (found),
      .none         (none)
   );

   always_comb begin
      adv_phase = none ? PH_FSPEC : PH_ITEM_START;
      adv_records = none ? records_ff + 16'd1 : records_ff;
      kind = item_kind(pos_ff);
      skip_dec = (skip_ff != 9'd0) ? skip_ff - 9'd1 : skip_ff;
      step = ctrl.step_en && (error_ff == ST_OK);
   end

   always_comb begin
      phase_in = phase_ff;
      fspec_first_in = fspec_first_ff;
      fspec_second_in = fspec_second_ff;
      fspec_octets_in = fspec_octets_ff;
      pos_in = pos_ff;
      skip_in = skip_ff;
      error_in = error_ff;
      records_in = records_ff;
      if (ctrl.hdr_done) begin
         phase_in = ctrl.cat_ok ? PH_FSPEC : PH_STOPPED;
      end else if (step) begin
         case (phase_ff)
            PH_FSPEC, PH_FSPEC_CONT: begin
               fspec_first_in = fs_first;
               fspec_second_in = fs_second;
               fspec_octets_in = fs_octets;
               if (data_byte[0]) begin
                  if (ctrl.fx_at_end) begin
                     error_in = ST_FSPEC_OVERRUN;
                     phase_in = PH_STOPPED;
                  end else begin
                     phase_in = PH_FSPEC_CONT;
                  end
               end else if ((fs_octets >= 2'd2) && ((fs_second & SPARE_MASK) != 8'h00)) begin
                  error_in = ST_SPARE;
                  phase_in = PH_STOPPED;
               end else if (fs_octets >= 2'd3) begin
                  error_in = ST_THIRD_FSPEC;
                  phase_in = PH_STOPPED;
               end else begin
                  pos_in = found;
                  phase_in = adv_phase;
                  records_in = adv_records;
               end
            end
            PH_ITEM_START: begin
               if (kind == K_REPEAT) begin
                  skip_in = {data_byte, 1'b0};
                  if (data_byte == 8'h00) begin
                     pos_in = found;
                     phase_in = adv_phase;
                     records_in = adv_records;
                  end else begin
                     phase_in = PH_ITEM_SKIP;
                  end
               end else if (kind == K_EXTEND) begin
                  if (data_byte[0]) begin
                     phase_in = PH_ITEM_EXT;
                  end else begin
                     pos_in = found;
                     phase_in = adv_phase;
                     records_in = adv_records;
                  end
               end else if (kind == K_EXPLICIT) begin
                  if (data_byte == 8'h00) begin
                     // A zero length byte ends the record and is then taken again as an
                     // empty FSPEC, which closes one more record.
                     records_in = records_ff + 16'd2;
                     fspec_first_in = 8'h00;
                     fspec_second_in = 8'h00;
                     fspec_octets_in = 2'd1;
                     pos_in = POS_W'(ITEM_COUNT);
                     phase_in = PH_FSPEC;
                  end else begin
                     skip_in = {1'b0, data_byte} - 9'd1;
                     if (data_byte == 8'd1) begin
                        pos_in = found;
                        phase_in = adv_phase;
                        records_in = adv_records;
                     end else begin
                        phase_in = PH_ITEM_SKIP;
                     end
                  end
               end else if (kind <= 8'd1) begin
                  pos_in = found;
                  phase_in = adv_phase;
                  records_in = adv_records;
               end else begin
                  skip_in = 9'(kind) - 9'd1;
                  phase_in = PH_ITEM_SKIP;
               end
            end
            PH_ITEM_SKIP: begin
               skip_in = skip_dec;
               if (skip_dec == 9'd0) begin
                  pos_in = found;
                  phase_in = adv_phase;
                  records_in = adv_records;
               end
            end
            PH_ITEM_EXT: begin
               if (!data_byte[0]) begin
                  pos_in = found;
                  phase_in = adv_phase;
                  records_in = adv_records;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      view.phase_fspec = (phase_in == PH_FSPEC);
      view.error = error_in;
      view.records = records_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (ctrl.fire && ctrl.last)) begin
         phase_ff <= PH_HEADER;
         fspec_first_ff <= '0;
         fspec_second_ff <= '0;
         fspec_octets_ff <= '0;
         pos_ff <= '0;
         skip_ff <= '0;
         error_ff <= ST_OK;
         records_ff <= '0;
      end else if (ctrl.fire) begin
         phase_ff <= phase_in;
         fspec_first_ff <= fspec_first_in;
         fspec_second_ff <= fspec_second_in;
         fspec_octets_ff <= fspec_octets_in;
         pos_ff <= pos_in;
         skip_ff <= skip_in;
         error_ff <= error_in;
         records_ff <= records_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/asterix019_record_validator_top.sv =====
// Top level of the category 019 record validator: handshakes, header checks, status.
// Depends on ast19_pkg, ast19_record_parser and assert_macros.svh.
//
//   channel  direction  ports                                     item
//   req      in         req_valid/ready, data_byte, last_byte     one message byte
//   rsp      out        rsp_valid/ready, status, count, trimmed   one result per message
//
// Each byte is parsed from the input register after it is accepted, so one byte is taken
// every cycle unless the last byte waits; the result register is loaded as the last byte is parsed.
// The byte marked last waits in the input register while the result register is full and not read;
// other bytes never wait on the result side.
// Synchronous reset clears all control state; a result also returns the parse state
// to its reset values for the next message.
`default_nettype none
module asterix019_record_validator_top import ast19_pkg::*; #(
   parameter int MAX_MESSAGE_BYTES = MAX_MESSAGE_BYTES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [3:0]       rsp_status,
   output logic [15:0]      rsp_record_count,
   output logic             rsp_length_trimmed
);

`include "assert_macros.svh"

   localparam int IDX_W = $clog2(MAX_MESSAGE_BYTES + 2);
   localparam int CMP_W = (IDX_W + 1 > 17) ? IDX_W + 1 : 17;

   logic              in_valid_ff;
   logic [7:0]        in_byte_ff;
   logic              in_last_ff;
   logic [IDX_W-1:0]  byte_index_ff, byte_index_in;
   logic [15:0]       declared_ff, declared_in;
   logic              cat_ok_ff, cat_ok_in;
   logic              rsp_valid_ff;
   status_type        rsp_status_ff, status_in;
   logic [15:0]       rsp_count_ff, count_in;
   logic              rsp_trim_ff, trim_in;

   logic              out_free, fire;
   logic [CMP_W-1:0]  idx_ext, idx_new_ext, decl_ext, decl_new_ext;
   parse_ctrl_type    ctrl;
   parse_view_type    view;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign fire = in_valid_ff && (!in_last_ff || out_free);
   assign req_ready = !in_valid_ff || fire;

   always_comb begin
      idx_ext = CMP_W'(byte_index_ff);
      decl_ext = CMP_W'(declared_ff);
      byte_index_in = (byte_index_ff <= IDX_W'(MAX_MESSAGE_BYTES)) ?
                      byte_index_ff + IDX_W'(1) : byte_index_ff;
      cat_ok_in = cat_ok_ff;
      declared_in = declared_ff;
      if (byte_index_ff == IDX_W'(0)) begin
         cat_ok_in = (in_byte_ff == CATEGORY_CODE);
      end else if (byte_index_ff == IDX_W'(1)) begin
         declared_in = {in_byte_ff, 8'h00};
      end else if (byte_index_ff == IDX_W'(2)) begin
         declared_in = {declared_ff[15:8], in_byte_ff};
      end
      idx_new_ext = CMP_W'(byte_index_in);
      decl_new_ext = CMP_W'(declared_in);
   end

   always_comb begin
      ctrl.fire = fire;
      ctrl.last = in_last_ff;
      ctrl.hdr_done = (byte_index_ff == IDX_W'(2));
      ctrl.cat_ok = cat_ok_ff;
      ctrl.step_en = (byte_index_ff > IDX_W'(2)) && cat_ok_ff && (idx_ext < decl_ext);
      ctrl.fx_at_end = (idx_ext + CMP_W'(1)) >= decl_ext;
   end

   ast19_record_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .data_byte (in_byte_ff),
      .view      (view)
   );

   always_comb begin
      status_in = ST_OK;
      count_in = '0;
      trim_in = 1'b0;
      if (byte_index_in > IDX_W'(MAX_MESSAGE_BYTES)) begin
         status_in = ST_OVERSIZE;
      end else if (byte_index_in < IDX_W'(3)) begin
         status_in = ST_SHORT_HEADER;
      end else if (!cat_ok_in) begin
         status_in = ST_CATEGORY;
      end else if (decl_new_ext > idx_new_ext) begin
         status_in = ST_LENGTH_OVER;
      end else begin
         trim_in = (decl_new_ext < idx_new_ext);
         count_in = view.records;
         if (view.error != ST_OK) begin
            status_in = view.error;
         end else if ((declared_in < 16'd3) || !view.phase_fspec) begin
            status_in = ST_RECORD_OVERRUN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (fire && in_last_ff)) begin
         byte_index_ff <= '0;
         declared_ff <= '0;
         cat_ok_ff <= 1'b0;
      end else if (fire) begin
         byte_index_ff <= byte_index_in;
         declared_ff <= declared_in;
         cat_ok_ff <= cat_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire && in_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && in_last_ff) begin
         rsp_status_ff <= status_in;
         rsp_count_ff <= count_in;
         rsp_trim_ff <= trim_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_record_count = rsp_count_ff;
   assign rsp_length_trimmed = rsp_trim_ff;

   `AST_ASSERT(a_result_follows_last, clock, reset, (fire && in_last_ff) |=> rsp_valid_ff, "no result after the last byte")
   `AST_ASSERT(a_header_cleared, clock, reset, (fire && in_last_ff) |=> (byte_index_ff == '0 && !cat_ok_ff), "header state not cleared after a result")
   `AST_NEVER(a_index_saturates, clock, reset, CMP_W'(byte_index_ff) > CMP_W'(MAX_MESSAGE_BYTES + 1), "byte index past saturation")
   `AST_NEVER(a_header_error_no_count, clock, reset, rsp_valid_ff && (rsp_status_ff == ST_OVERSIZE || rsp_status_ff == ST_SHORT_HEADER || rsp_status_ff == ST_CATEGORY || rsp_status_ff == ST_LENGTH_OVER) && (rsp_count_ff != 16'd0), "record count given with a header error")

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the category 019 record validator: directed messages and
// random messages, each result checked against a table entry or a local parser.
// Depends on ast19_pkg and asterix019_record_validator_top.
`default_nettype none
module testbench import ast19_pkg::*;;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned HOLD_CYCLES = 400;

   localparam logic [8*ITEM_COUNT-1:0] ITEM_FORMS = {
      K_EXPLICIT, K_EXPLICIT, K_SPARE, K_SPARE, 8'd1, 8'd2, 8'd8,
      K_EXTEND, K_REPEAT, 8'd1, 8'd1, 8'd3, 8'd1, 8'd2};

   typedef struct packed {
      status_type  status;
      logic [15:0] records;
      logic        trimmed;
   } verdict_type;

   typedef struct packed {
      int unsigned  len;
      logic [255:0] bytes;
      bit           typed;
      verdict_type  want;
   } message_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [3:0]  rsp_status;
   logic [15:0] rsp_record_count;
   logic        rsp_length_trimmed;

   verdict_type     awaited_verdicts[$];
   message_row_type directed_messages[$];
   logic [7:0]      outgoing[$];
   int unsigned     mismatch_count = 0;
   int unsigned     cycle_count = 0;
   bit              idle_on = 1'b1;
   bit              hold_request = 1'b0;

   // Parser state mirrored from the byte stream.
   int unsigned  seen_bytes;
   int unsigned  decl_len;
   bit           cat_ok;
   phase_type    phase;
   logic [7:0]   fspec1;
   logic [7:0]   fspec2;
   int unsigned  fspec_n;
   int unsigned  item_pos;
   int unsigned  skip_left;
   status_type   parse_err;
   logic [15:0]  rec_count;

   asterix019_record_validator_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_record_count   (rsp_record_count),
      .rsp_length_trimmed (rsp_length_trimmed)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void append_byte(input logic [7:0] b);
      outgoing.insert(outgoing.size(), b);
   endfunction

   function automatic void restart_parse();
      seen_bytes = 0;
      decl_len = 0;
      cat_ok = 1'b0;
      phase = PH_HEADER;
      fspec1 = 8'h00;
      fspec2 = 8'h00;
      fspec_n = 0;
      item_pos = 0;
      skip_left = 0;
      parse_err = ST_OK;
      rec_count = 16'd0;
   endfunction

   function automatic void halt(input status_type code);
      parse_err = code;
      phase = PH_STOPPED;
   endfunction

   function automatic bit item_marked(input int unsigned p);
      if (p < 7) return fspec1[7-p];
      if (p < ITEM_COUNT && fspec_n >= 2 && ITEM_FORMS[8*p +: 8] != K_SPARE)
         return fspec2[14-p];
      return 1'b0;
   endfunction

   function automatic void seek_item();
      while (item_pos < ITEM_COUNT && !item_marked(item_pos)) item_pos++;
      if (item_pos >= ITEM_COUNT) begin
         rec_count = rec_count + 16'd1;
         phase = PH_FSPEC;
      end else begin
         phase = PH_ITEM_START;
      end
   endfunction

   function automatic void next_item();
      item_pos++;
      seek_item();
   endfunction

   function automatic void close_fspec(input logic [7:0] b, input int unsigned i);
      if (b[0]) begin
         if (i + 1 >= decl_len) halt(ST_FSPEC_OVERRUN);
         else phase = PH_FSPEC_CONT;
      end else if (fspec_n >= 2 && (fspec2 & SPARE_MASK) != 8'h00) begin
         halt(ST_SPARE);
      end else if (fspec_n >= 3) begin
         halt(ST_THIRD_FSPEC);
      end else begin
         item_pos = 0;
         seek_item();
      end
   endfunction

   // Returns 0 when an explicit length of zero leaves the byte to be read again.
   function automatic bit take_byte(input logic [7:0] b, input int unsigned i);
      logic [7:0] form;
      form = (item_pos < ITEM_COUNT) ? ITEM_FORMS[8*item_pos +: 8] : K_SPARE;
      case (phase)
         PH_FSPEC: begin
            fspec1 = b;
            fspec2 = 8'h00;
            fspec_n = 1;
            close_fspec(b, i);
         end
         PH_FSPEC_CONT: begin
            if (fspec_n == 1) fspec2 = b;
            if (fspec_n < 3) fspec_n++;
            close_fspec(b, i);
         end
         PH_ITEM_START: begin
            if (form == K_REPEAT) begin
               skip_left = 2 * b;
               if (skip_left == 0) next_item();
               else phase = PH_ITEM_SKIP;
            end else if (form == K_EXTEND) begin
               if (b[0]) phase = PH_ITEM_EXT;
               else next_item();
            end else if (form == K_EXPLICIT) begin
               if (b == 8'h00) begin
                  next_item();
                  return 1'b0;
               end
               skip_left = b - 1;
               if (skip_left == 0) next_item();
               else phase = PH_ITEM_SKIP;
            end else if (form <= 8'd1) begin
               next_item();
            end else begin
               skip_left = form - 1;
               phase = PH_ITEM_SKIP;
            end
         end
         PH_ITEM_SKIP: begin
            if (skip_left > 0) skip_left--;
            if (skip_left == 0) next_item();
         end
         PH_ITEM_EXT: begin
            if (!b[0]) next_item();
         end
         default: ;
      endcase
      return 1'b1;
   endfunction

   function automatic bit parse_byte(input logic [7:0] b, input logic last,
                                     output verdict_type v);
      int unsigned i;
      int unsigned k;
      i = seen_bytes;
      v.status = ST_OK;
      v.records = 16'd0;
      v.trimmed = 1'b0;
      if (seen_bytes <= MAX_MESSAGE_BYTES_DEF) seen_bytes++;
      if (i == 0) begin
         cat_ok = (b == CATEGORY_CODE);
      end else if (i == 1) begin
         decl_len = 256 * b;
      end else if (i == 2) begin
         decl_len = decl_len + b;
         phase = cat_ok ? PH_FSPEC : PH_STOPPED;
      end else if (cat_ok && parse_err == ST_OK && i < decl_len) begin
         k = 0;
         while (k < 4 && !take_byte(b, i)) k++;
      end
      if (!last) return 1'b0;
      if (seen_bytes > MAX_MESSAGE_BYTES_DEF) begin
         v.status = ST_OVERSIZE;
      end else if (seen_bytes < 3) begin
         v.status = ST_SHORT_HEADER;
      end else if (!cat_ok) begin
         v.status = ST_CATEGORY;
      end else if (decl_len > seen_bytes) begin
         v.status = ST_LENGTH_OVER;
      end else begin
         v.trimmed = (decl_len < seen_bytes);
         v.records = rec_count;
         if (parse_err != ST_OK) v.status = parse_err;
         else if (decl_len < 3 || phase != PH_FSPEC) v.status = ST_RECORD_OVERRUN;
      end
      restart_parse();
      return 1'b1;
   endfunction

   function automatic void add_message(input int unsigned n, input logic [255:0] v,
                                       input bit typed, input status_type st,
                                       input logic [15:0] cnt, input logic trim);
      message_row_type row;
      row.len = n;
      row.bytes = v;
      row.typed = typed;
      row.want.status = st;
      row.want.records = cnt;
      row.want.trimmed = trim;
      directed_messages.insert(directed_messages.size(), row);
   endfunction

   // Mostly well-formed messages with random item content, plus noise and bad lengths.
   function automatic void compose_message();
      int unsigned mode, nrec, p, n, c, r, total, decl;
      logic [7:0] f1, f2, form;
      bit on;
      outgoing.delete();
      mode = $urandom_range(0, 99);
      if (mode < 6) begin
         n = $urandom_range(1, 12);
         repeat (n) append_byte(8'($urandom));
         if (mode < 3) outgoing[0] = CATEGORY_CODE;
         return;
      end
      append_byte(CATEGORY_CODE);
      append_byte(8'h00);
      append_byte(8'h00);
      nrec = $urandom_range(0, 5);
      repeat (nrec) begin
         f1 = 8'($urandom);
         f2 = 8'($urandom) & ~SPARE_MASK & 8'hFE;
         if ($urandom_range(0, 19) == 0) f2 = 8'($urandom);
         append_byte(f1);
         if (f1[0]) begin
            append_byte(f2);
            if (f2[0]) append_byte(8'($urandom));
         end
         for (p = 0; p < ITEM_COUNT; p++) begin
            form = ITEM_FORMS[8*p +: 8];
            if (p < 7) on = f1[7-p];
            else on = f1[0] && form != K_SPARE && f2[14-p];
            if (on) begin
               if (form == K_REPEAT) begin
                  c = ($urandom_range(0, 39) == 0) ? $urandom_range(0, 255)
                                                   : $urandom_range(0, 3);
                  append_byte(8'(c));
                  repeat (2 * c) append_byte(8'($urandom));
               end else if (form == K_EXTEND) begin
                  n = $urandom_range(1, 3);
                  repeat (n - 1) append_byte(8'($urandom) | 8'h01);
                  append_byte(8'($urandom) & 8'hFE);
               end else if (form == K_EXPLICIT) begin
                  r = $urandom_range(0, 19);
                  c = (r == 0) ? 0 : (r == 1) ? $urandom_range(7, 255) : $urandom_range(1, 6);
                  append_byte(8'(c));
                  if (c > 1) repeat (c - 1) append_byte(8'($urandom));
               end else begin
                  repeat (form) append_byte(8'($urandom));
               end
            end
         end
      end
      total = outgoing.size();
      decl = total;
      r = $urandom_range(0, 99);
      if (r < 12) repeat ($urandom_range(1, 5)) append_byte(8'($urandom));
      else if (r < 20) decl = total + $urandom_range(1, 3);
      else if (r < 27 && total > 3) decl = total - $urandom_range(1, total - 3);
      else if (r < 30) decl = $urandom_range(0, 2);
      else if (r < 33) outgoing[0] = 8'($urandom);
      outgoing[1] = 8'(decl >> 8);
      outgoing[2] = 8'(decl);
   endfunction

   task automatic offer_byte(input logic [7:0] b, input logic last, input bit typed,
                             input verdict_type want);
      verdict_type got;
      if (idle_on && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (parse_byte(b, last, got))
         awaited_verdicts.insert(awaited_verdicts.size(), typed ? want : got);
   endtask

   task automatic send_message(input bit typed, input verdict_type want);
      int unsigned k;
      for (k = 0; k < outgoing.size(); k++)
         offer_byte(outgoing[k], k == outgoing.size() - 1, typed, want);
   endtask

   initial begin
      int unsigned r, k, sent, msgs;
      verdict_type none;
      none = '0;
      restart_parse();
      add_message(1, 256'h13, 1'b1, ST_SHORT_HEADER, 16'd0, 1'b0);
      add_message(2, 256'h1300, 1'b1, ST_SHORT_HEADER, 16'd0, 1'b0);
      add_message(3, 256'h130003, 1'b1, ST_OK, 16'd0, 1'b0);
      add_message(3, 256'h140003, 1'b1, ST_CATEGORY, 16'd0, 1'b0);
      add_message(3, 256'hFFFFFF, 1'b1, ST_CATEGORY, 16'd0, 1'b0);
      add_message(4, 256'h13000800, 1'b1, ST_LENGTH_OVER, 16'd0, 1'b0);
      add_message(3, 256'h13FF00, 1'b1, ST_LENGTH_OVER, 16'd0, 1'b0);
      add_message(3, 256'h130000, 1'b1, ST_RECORD_OVERRUN, 16'd0, 1'b1);
      add_message(6, 256'h13000400_55AA, 1'b1, ST_OK, 16'd1, 1'b1);
      add_message(4, 256'h13000401, 1'b1, ST_FSPEC_OVERRUN, 16'd0, 1'b0);
      add_message(7, 256'h13000401_FFFFFF, 1'b1, ST_FSPEC_OVERRUN, 16'd0, 1'b1);
      add_message(5, 256'h13000501_10, 1'b1, ST_SPARE, 16'd0, 1'b0);
      add_message(5, 256'h13000501_08, 1'b1, ST_SPARE, 16'd0, 1'b0);
      add_message(5, 256'h13000501_11, 1'b1, ST_FSPEC_OVERRUN, 16'd0, 1'b0);
      add_message(5, 256'h13000501_01, 1'b1, ST_FSPEC_OVERRUN, 16'd0, 1'b0);
      add_message(7, 256'h13000701_010000, 1'b1, ST_THIRD_FSPEC, 16'd0, 1'b0);
      add_message(5, 256'h13000580_00, 1'b1, ST_RECORD_OVERRUN, 16'd0, 1'b0);
      add_message(8, 256'h13000800_00000000, 1'b1, ST_OK, 16'd5, 1'b0);
      add_message(20, 256'h130014_FE_AABB_CC_112233_44_55_0201020304_810100, 1'b0,
                  ST_OK, 16'd0, 1'b0);
      add_message(20, 256'h130014_01E6_0102030405060708_F00F_80_03A55A_00, 1'b0,
                  ST_OK, 16'd0, 1'b0);
      add_message(5, 256'h13000504_00, 1'b0, ST_OK, 16'd0, 1'b0);
      add_message(6, 256'h13000601_0401, 1'b0, ST_OK, 16'd0, 1'b0);
      add_message(6, 256'h13000601_0200, 1'b0, ST_OK, 16'd0, 1'b0);
      add_message(6, 256'h13000602_8181, 1'b0, ST_OK, 16'd0, 1'b0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (r = 0; r < directed_messages.size(); r++) begin
         outgoing.delete();
         for (k = 0; k < directed_messages[r].len; k++)
            append_byte(directed_messages[r].bytes[8*(directed_messages[r].len-1-k) +: 8]);
         send_message(directed_messages[r].typed, directed_messages[r].want);
      end

      sent = 0;
      msgs = 0;
      while (sent < 1300 || msgs < 12) begin
         if (msgs % 8 == 0) idle_on = ($urandom_range(0, 3) != 0);
         if (msgs == 10) hold_request = 1'b1;
         compose_message();
         send_message(1'b0, none);
         sent += outgoing.size();
         msgs++;
      end
      idle_on = 1'b0;
      repeat (8) begin
         compose_message();
         send_message(1'b0, none);
      end
      req_valid <= 1'b0;

      while (awaited_verdicts.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

   initial begin
      bit held;
      held = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_request && !held) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_verdicts.size() == 0) begin
            $error("result item with no expectation pending");
            mismatch_count++;
         end else begin
            want = awaited_verdicts.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_record_count !== want.records) begin
               $error("record_count: expected %0d, got %0d", want.records, rsp_record_count);
               mismatch_count++;
            end
            if (rsp_length_trimmed !== want.trimmed) begin
               $error("length_trimmed: expected %0d, got %0d", want.trimmed,
                      rsp_length_trimmed);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/ast19_pkg.sv
rtl/ast19_item_search.sv
rtl/ast19_record_parser.sv
rtl/asterix019_record_validator_top.sv
tb/testbench.sv
